FILE: hdl/assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_SYNC(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hdl/ipid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

    localparam int CFG_W   = 16;
    localparam int ACT_W   = 32;
    localparam int DRIVE_W = 16;
    localparam int OUT_DATA_W = ((DRIVE_W + 2 + 7) / 8) * 8;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 12;

    typedef enum logic [2:0] {
        REG_COEF_CURRENT  = 3'd0,
        REG_COEF_PREVIOUS = 3'd1,
        REG_COEF_OLDER    = 3'd2,
        REG_FEEDBACK_GAIN = 3'd3,
        REG_SETPOINT      = 3'd4,
        REG_DRIVE_BIAS    = 3'd5,
        REG_DRIVE_UPPER   = 3'd6,
        REG_DRIVE_LOWER   = 3'd7
    } t_reg_idx;

    localparam logic signed [CFG_W-1:0] GAIN_RST  = 16'sd4096;
    localparam logic signed [CFG_W-1:0] UPPER_RST = 16'sh7fff;
    localparam logic signed [CFG_W-1:0] LOWER_RST = 16'sh8000;

endpackage

`default_nettype wire

FILE: hdl/incremental_pid_with_clamp.sv
// a sample's result is offered once it has passed the sample, action and output registers
// throughput: one sample per cycle while the output is not stalled, set by the combinational
//   action update (four parallel multiplies summed) that closes the loop on the stored action
// the whole pipeline holds while the output register waits for a transfer
// reset (synchronous, active low) restores the register defaults and clears
//   the error history, the action and all valid flags
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module incremental_pid_with_clamp
    import ipid_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sensor_sample
    input  wire  [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // drive_value, hit_upper, hit_lower
    output logic [OUT_DATA_W-1:0]                m_axis_tdata,
    input  wire                                  i_cfg_we,
    input  wire  [2:0]                           i_cfg_addr,
    input  wire  [CFG_W-1:0]                     i_cfg_data
);

    localparam int EW = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 1;
    localparam int PW = CFG_W + EW;
    localparam int FW = CFG_W + ACT_W;
    localparam int SW = FW + 3;

    logic signed [CFG_W-1:0] r_coef0, r_coef1, r_coef2, r_gain;
    logic signed [CFG_W-1:0] r_setpoint, r_bias, r_upper, r_lower;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [EW-1:0]          r_err0, r_err1;
    logic signed [ACT_W-1:0]       r_action;
    logic                          r_v1, r_v2, r_vo;
    logic [DRIVE_W-1:0]            r_drive;
    logic                          r_hit_up, r_hit_lo;

    logic                          w_adv;
    logic signed [EW-1:0]          n_err0;
    logic signed [PW-1:0]          w_p0, w_p1, w_p2;
    logic signed [FW-1:0]          w_pf;
    logic signed [SW-1:0]          w_sum, w_shift;
    logic                          w_ovf_pos, w_ovf_neg;
    logic signed [ACT_W-1:0]       n_action;
    logic signed [ACT_W:0]         w_cmd;

    assign w_adv         = !r_vo || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {(OUT_DATA_W - DRIVE_W - 2)'(0), r_hit_lo, r_hit_up, r_drive};

    // action update
    always_comb begin
        n_err0    = EW'(r_setpoint) - EW'(r_sample);
        w_p0      = r_coef0 * n_err0;
        w_p1      = r_coef1 * r_err0;
        w_p2      = r_coef2 * r_err1;
        w_pf      = r_gain * r_action;
        w_sum     = SW'(w_pf) + SW'(w_p0) + SW'(w_p1) + SW'(w_p2);
        w_shift   = w_sum >>> COEF_FRAC_BITS;
        w_ovf_pos = !w_shift[SW-1] && (|w_shift[SW-2:ACT_W-1]);
        w_ovf_neg = w_shift[SW-1] && !(&w_shift[SW-2:ACT_W-1]);
        priority if (w_ovf_pos) begin
            n_action = {1'b0, {(ACT_W-1){1'b1}}};
        end else if (w_ovf_neg) begin
            n_action = {1'b1, {(ACT_W-1){1'b0}}};
        end else begin
            n_action = w_shift[ACT_W-1:0];
        end
        w_cmd = (ACT_W+1)'(r_bias) + (ACT_W+1)'(r_action);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef0    <= '0;
            r_coef1    <= '0;
            r_coef2    <= '0;
            r_gain     <= GAIN_RST;
            r_setpoint <= '0;
            r_bias     <= '0;
            r_upper    <= UPPER_RST;
            r_lower    <= LOWER_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_COEF_CURRENT:  r_coef0    <= i_cfg_data;
                REG_COEF_PREVIOUS: r_coef1    <= i_cfg_data;
                REG_COEF_OLDER:    r_coef2    <= i_cfg_data;
                REG_FEEDBACK_GAIN: r_gain     <= i_cfg_data;
                REG_SETPOINT:      r_setpoint <= i_cfg_data;
                REG_DRIVE_BIAS:    r_bias     <= i_cfg_data;
                REG_DRIVE_UPPER:   r_upper    <= i_cfg_data;
                REG_DRIVE_LOWER:   r_lower    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_vo     <= 1'b0;
            r_err0   <= '0;
            r_err1   <= '0;
            r_action <= '0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_vo <= r_v2;
            if (r_v1) begin
                r_err0   <= n_err0;
                r_err1   <= r_err0;
                r_action <= n_action;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv && s_axis_tvalid) begin
            r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (w_adv && r_v2) begin
            priority if (w_cmd > (ACT_W+1)'(r_upper)) begin
                r_drive  <= r_upper;
                r_hit_up <= 1'b1;
                r_hit_lo <= 1'b0;
            end else if (w_cmd < (ACT_W+1)'(r_lower)) begin
                r_drive  <= r_lower;
                r_hit_up <= 1'b0;
                r_hit_lo <= 1'b1;
            end else begin
                r_drive  <= w_cmd[DRIVE_W-1:0];
                r_hit_up <= 1'b0;
                r_hit_lo <= 1'b0;
            end
        end
    end

    `ASSERT_SYNC(a_flags_exclusive, i_clk, i_rst_n, r_vo |-> !(r_hit_up && r_hit_lo))
    `ASSERT_SYNC(a_action_holds_on_stall, i_clk, i_rst_n, !w_adv |=> $stable(r_action))
    `ASSERT_SYNC(a_staged_item_kept, i_clk, i_rst_n, (r_v1 && !w_adv) |=> r_v1)

endmodule

`default_nettype wire

FILE: sim/incremental_pid_with_clamp_tb.sv
`timescale 1ns / 1ps

module incremental_pid_with_clamp_tb;
    import ipid_pkg::*;

    localparam longint ACT_HI = 64'sd2147483647;
    localparam longint ACT_LO = -64'sd2147483648;

    typedef struct packed {
        logic        is_write;
        t_reg_idx    reg_idx;
        logic [15:0] value;
    } stim_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               hit_upper;
        logic               hit_lower;
    } drive_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    // sensor_sample
    logic [15:0]           s_axis_tdata = '0;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // drive_value, hit_upper, hit_lower
    wire  [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    t_reg_idx              i_cfg_addr = REG_COEF_CURRENT;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    stim_t  stim_q[$];
    drive_t drive_expected[$];

    // controller shadow state
    logic signed [15:0] cfg_regs [8] = '{16'sd0, 16'sd0, 16'sd0, GAIN_RST,
                                         16'sd0, 16'sd0, UPPER_RST, LOWER_RST};
    logic signed [16:0] err_hist [3] = '{default: '0};
    logic signed [31:0] act_reg = '0;

    int samples_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settle = 0;
    logic rx_hold = 1'b0;

    incremental_pid_with_clamp i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic drive_t pid_drive_step(logic signed [15:0] sample);
        longint acc;
        longint cmd;
        drive_t res;
        err_hist[2] = err_hist[1];
        err_hist[1] = err_hist[0];
        err_hist[0] = 17'(longint'(cfg_regs[REG_SETPOINT]) - longint'(sample));
        acc = longint'(cfg_regs[REG_FEEDBACK_GAIN]) * longint'(act_reg)
            + longint'(cfg_regs[REG_COEF_CURRENT]) * longint'(err_hist[0])
            + longint'(cfg_regs[REG_COEF_PREVIOUS]) * longint'(err_hist[1])
            + longint'(cfg_regs[REG_COEF_OLDER]) * longint'(err_hist[2]);
        acc = acc >>> COEF_FRAC_BITS_DEF;
        if (acc > ACT_HI) begin
            acc = ACT_HI;
        end else if (acc < ACT_LO) begin
            acc = ACT_LO;
        end
        act_reg = acc[31:0];
        cmd = longint'(cfg_regs[REG_DRIVE_BIAS]) + longint'(act_reg);
        res = '0;
        if (cmd > longint'(cfg_regs[REG_DRIVE_UPPER])) begin
            res.drive = cfg_regs[REG_DRIVE_UPPER];
            res.hit_upper = 1'b1;
        end else if (cmd < longint'(cfg_regs[REG_DRIVE_LOWER])) begin
            res.drive = cfg_regs[REG_DRIVE_LOWER];
            res.hit_lower = 1'b1;
        end else begin
            res.drive = cmd[15:0];
        end
        return res;
    endfunction

    function automatic int rand_span(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic add_write(t_reg_idx idx, int v);
        stim_q.push_back('{1'b1, idx, 16'(v)});
    endtask

    task automatic add_sample(int v);
        stim_q.push_back('{1'b0, REG_COEF_CURRENT, 16'(v)});
    endtask

    // sample driver, register writes only once the pipeline has drained
    always @(posedge i_clk) begin
        logic        nxt_valid;
        logic [15:0] nxt_data;
        logic        nxt_we;
        logic        calm;
        nxt_valid = s_axis_tvalid;
        nxt_data = s_axis_tdata;
        nxt_we = 1'b0;
        calm = (samples_sent >= 200) && (samples_sent < 300);
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                drive_expected.push_back(pid_drive_step(s_axis_tdata));
                samples_sent++;
                nxt_valid = 1'b0;
            end
            if (drive_expected.size() == 0 && !s_axis_tvalid) begin
                settle++;
            end else begin
                settle = 0;
            end
            if (!nxt_valid && stim_q.size() != 0) begin
                if (stim_q[0].is_write) begin
                    if (settle >= 3) begin
                        cfg_regs[stim_q[0].reg_idx] = stim_q[0].value;
                        i_cfg_addr <= stim_q[0].reg_idx;
                        i_cfg_data <= stim_q[0].value;
                        nxt_we = 1'b1;
                        stim_q.delete(0);
                    end
                end else if (calm || $urandom_range(99) >= 9) begin
                    nxt_data = stim_q[0].value;
                    nxt_valid = 1'b1;
                    stim_q.delete(0);
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata <= nxt_data;
        i_cfg_we <= nxt_we;
    end

    // result checker and output back-pressure
    always @(posedge i_clk) begin
        drive_t want;
        logic   calm;
        calm = (results_seen >= 200) && (results_seen < 300);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (drive_expected.size() == 0) begin
                $error("unexpected output transfer, data %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = drive_expected.pop_front();
                if (m_axis_tdata[15:0] !== want.drive) begin
                    $error("drive_value: expected %0d, actual %0d",
                           want.drive, $signed(m_axis_tdata[15:0]));
                    mismatches++;
                end
                if (m_axis_tdata[16] !== want.hit_upper) begin
                    $error("hit_upper: expected %0d, actual %0d",
                           want.hit_upper, m_axis_tdata[16]);
                    mismatches++;
                end
                if (m_axis_tdata[17] !== want.hit_lower) begin
                    $error("hit_lower: expected %0d, actual %0d",
                           want.hit_lower, m_axis_tdata[17]);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= !rx_hold && (calm || $urandom_range(99) >= 9);
    end

    // long output stall so the pipeline backs up into the input
    initial begin
        wait (results_seen >= 360);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (80) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #400000;
        $display("incremental_pid_with_clamp_tb: FAIL");
        $finish;
    end

    initial begin
        int span;
        int sp;
        int lim_a;
        int lim_b;

        // default registers: action stays at zero
        add_sample(-32768);
        add_sample(32767);
        add_sample(0);
        add_sample(-1);

        add_write(REG_COEF_CURRENT, 4096);
        add_write(REG_COEF_PREVIOUS, -4096);
        add_write(REG_SETPOINT, 100);
        add_sample(100);
        add_sample(-32768);
        add_sample(32767);
        add_sample(0);

        // large gains drive the action into saturation, clamp at the lower limit
        add_write(REG_COEF_CURRENT, 32767);
        add_write(REG_COEF_PREVIOUS, -32768);
        add_write(REG_COEF_OLDER, 32767);
        add_write(REG_FEEDBACK_GAIN, 32767);
        add_write(REG_SETPOINT, -32768);
        add_write(REG_DRIVE_BIAS, 32767);
        add_write(REG_DRIVE_UPPER, 1000);
        add_write(REG_DRIVE_LOWER, -1000);
        repeat (4) add_sample(32767);
        repeat (2) add_sample(-32768);

        // negative feedback swings the action, limits inverted
        add_write(REG_FEEDBACK_GAIN, -32768);
        add_write(REG_SETPOINT, 32767);
        add_write(REG_DRIVE_BIAS, -32768);
        add_write(REG_DRIVE_UPPER, -32768);
        add_write(REG_DRIVE_LOWER, 32767);
        repeat (3) add_sample(-32768);
        repeat (2) add_sample(0);

        // command exactly on both limits
        add_write(REG_COEF_CURRENT, 0);
        add_write(REG_COEF_PREVIOUS, 0);
        add_write(REG_COEF_OLDER, 0);
        add_write(REG_FEEDBACK_GAIN, 0);
        add_write(REG_DRIVE_BIAS, 500);
        add_write(REG_DRIVE_UPPER, 500);
        add_write(REG_DRIVE_LOWER, 500);
        repeat (2) add_sample(1234);

        for (int ph = 0; ph < 6; ph++) begin
            span = (ph % 3 == 0) ? 256 : (ph % 3 == 1) ? 4096 : 32767;
            add_write(REG_COEF_CURRENT, rand_span(span));
            add_write(REG_COEF_PREVIOUS, rand_span(span));
            add_write(REG_COEF_OLDER, rand_span(span));
            add_write(REG_FEEDBACK_GAIN,
                      ($urandom_range(9) < 7) ? rand_span(4096) : int'(16'($urandom)));
            sp = rand_span(32767);
            add_write(REG_SETPOINT, sp);
            add_write(REG_DRIVE_BIAS, rand_span(8000));
            lim_a = int'($signed(16'($urandom)));
            lim_b = int'($signed(16'($urandom)));
            if ($urandom_range(9) < 8 && lim_a < lim_b) begin
                add_write(REG_DRIVE_UPPER, lim_b);
                add_write(REG_DRIVE_LOWER, lim_a);
            end else begin
                add_write(REG_DRIVE_UPPER, lim_a);
                add_write(REG_DRIVE_LOWER, lim_b);
            end
            repeat (75) begin
                if ($urandom_range(9) < 6) begin
                    add_sample(sp + rand_span(300));
                end else begin
                    add_sample(int'(16'($urandom)));
                end
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_axis_tvalid || drive_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("incremental_pid_with_clamp_tb: PASS");
        end else begin
            $display("incremental_pid_with_clamp_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: incremental_pid_with_clamp.f
+incdir+hdl
hdl/ipid_pkg.sv
hdl/incremental_pid_with_clamp.sv
sim/incremental_pid_with_clamp_tb.sv
